>>> sv/cvn_pkg.sv
// ----------------------------------------------------------------------------
// cvn_pkg
// Shared constants and types of the complex vector norm unit with its two
// redundant accumulators.
// ----------------------------------------------------------------------------
package cvn_pkg;

  // Default widths of one element part and of the accumulators.
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int SUM_WIDTH_DEF    = 48;

  // Depth of the queue between the accumulating front and the root back end.
  // It must be a power of two.
  localparam int QUEUE_DEPTH_DEF  = 2;

  // Fixed field widths.
  localparam int STRIDE_W = 8;
  localparam int NORM_W   = 24;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 8'd1;
  localparam logic [NORM_W-1:0]   NORM_MAX     = {NORM_W{1'b1}};

  // Status that travels with each finished vector sum.
  typedef struct packed {
    logic mismatch;   // the two accumulators disagreed
    logic saturated;  // an accumulator saturated during the vector
    logic zero_norm;  // stride was zero: the norm is forced to zero
  } cvn_flags_t;

endpackage

>>> sv/cvn_in_if.sv
// ----------------------------------------------------------------------------
// cvn_in_if
// Element channel: one complex element per request, with its last flag.
// ----------------------------------------------------------------------------
interface cvn_in_if #(
  parameter int SAMPLE_WIDTH = cvn_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] real_part;
  logic signed [SAMPLE_WIDTH-1:0] imag_part;
  logic                           last;

  modport source (output valid, real_part, imag_part, last, input ready);
  modport sink (input valid, real_part, imag_part, last, output ready);
endinterface

>>> sv/cvn_out_if.sv
// ----------------------------------------------------------------------------
// cvn_out_if
// Result channel: one norm with its status flags per request.
// ----------------------------------------------------------------------------
interface cvn_out_if ();
  logic                        valid;
  logic                        ready;
  logic [cvn_pkg::NORM_W-1:0]  norm;
  logic                        mismatch;
  logic                        saturated;

  modport source (output valid, norm, mismatch, saturated, input ready);
  modport sink (input valid, norm, mismatch, saturated, output ready);
endinterface

>>> sv/cvn_cfg_if.sv
// ----------------------------------------------------------------------------
// cvn_cfg_if
// Configuration channel: each request writes the stride register.
// ----------------------------------------------------------------------------
interface cvn_cfg_if ();
  logic                          valid;
  logic                          ready;
  logic [cvn_pkg::STRIDE_W-1:0]  stride;

  modport source (output valid, stride, input ready);
  modport sink (input valid, stride, output ready);
endinterface

>>> sv/cvn_front.sv
// ----------------------------------------------------------------------------
// cvn_front
// Accepts elements, selects them by stride, squares them and accumulates
// them into the primary and shadow sums; hands each finished vector on.
// ----------------------------------------------------------------------------
module cvn_front #(
  parameter int SAMPLE_WIDTH = cvn_pkg::SAMPLE_WIDTH_DEF,
  parameter int SUM_WIDTH    = cvn_pkg::SUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  cvn_cfg_if.sink              cfg,
  cvn_in_if.sink               elem,
  input  logic                 q_full,
  output logic                 push,
  output logic [SUM_WIDTH-1:0] push_sum,
  output cvn_pkg::cvn_flags_t  push_flags
);

  localparam int SQ_W  = 2 * SAMPLE_WIDTH;
  localparam int EXT_W = ((SQ_W > SUM_WIDTH) ? SQ_W : SUM_WIDTH) + 1;
  localparam logic [EXT_W-1:0]     SUM_MAX_EXT = EXT_W'({SUM_WIDTH{1'b1}});
  localparam logic [SUM_WIDTH-1:0] SUM_MAX     = {SUM_WIDTH{1'b1}};

  // Configuration and selection state.
  logic [cvn_pkg::STRIDE_W-1:0] stride;
  logic [cvn_pkg::STRIDE_W-1:0] skip_count;
  logic                         advance;
  logic                         accept;
  logic                         take;
  logic                         stride_zero;

  // Stage one: squared magnitudes.
  logic                    s1_valid;
  logic                    s1_last;
  logic                    s1_take;
  logic                    s1_zero;
  logic [SQ_W-1:0]         sq_re;
  logic [SQ_W-1:0]         sq_im;

  // Stage two: saturated term.
  logic                    s2_valid;
  logic                    s2_last;
  logic                    s2_take;
  logic                    s2_zero;
  logic                    s2_term_sat;
  logic [SUM_WIDTH-1:0]    s2_term;

  // Accumulators.
  logic [SUM_WIDTH-1:0]    primary_sum;
  logic [SUM_WIDTH-1:0]    shadow_sum;
  logic                    saturate_seen;

  logic [SAMPLE_WIDTH-1:0] raw_re;
  logic [SAMPLE_WIDTH-1:0] raw_im;
  logic [SAMPLE_WIDTH-1:0] mag_re;
  logic [SAMPLE_WIDTH-1:0] mag_im;
  logic [EXT_W-1:0]        re_clamp;
  logic [EXT_W-1:0]        term_ext;
  logic                    term_sat;
  logic [SUM_WIDTH-1:0]    term_next;
  logic [SUM_WIDTH:0]      p_ext;
  logic [SUM_WIDTH:0]      s_ext;
  logic                    p_sat;
  logic                    s_sat;
  logic [SUM_WIDTH-1:0]    primary_sum_next;
  logic [SUM_WIDTH-1:0]    shadow_sum_next;
  logic                    sat_now;

  assign cfg.ready = 1'b1;

  // The pipeline holds while a finished vector waits for room in the queue.
  assign advance    = !(s2_valid && s2_last && q_full);
  assign elem.ready = advance;
  assign accept     = elem.valid && advance;

  // An element is taken when the stride is non-zero and no skips remain.
  assign stride_zero = (stride == '0);
  assign take        = !stride_zero && (skip_count == '0);

  // Magnitudes of the two signed parts; the most negative value maps to
  // its positive magnitude, which still fits unsigned.
  assign raw_re = elem.real_part;
  assign raw_im = elem.imag_part;
  assign mag_re = raw_re[SAMPLE_WIDTH-1] ? (~raw_re + SAMPLE_WIDTH'(1)) : raw_re;
  assign mag_im = raw_im[SAMPLE_WIDTH-1] ? (~raw_im + SAMPLE_WIDTH'(1)) : raw_im;

  // Term: the real square is clamped first, then the imaginary square added.
  always_comb begin
    re_clamp  = (EXT_W'(sq_re) > SUM_MAX_EXT) ? SUM_MAX_EXT : EXT_W'(sq_re);
    term_ext  = re_clamp + EXT_W'(sq_im);
    term_sat  = (term_ext > SUM_MAX_EXT);
    term_next = term_sat ? SUM_MAX : term_ext[SUM_WIDTH-1:0];
  end

  // Saturating accumulation into both sums.
  always_comb begin
    p_ext = {1'b0, primary_sum} + {1'b0, s2_term};
    s_ext = {1'b0, shadow_sum} + {1'b0, s2_term};
    p_sat = p_ext[SUM_WIDTH];
    s_sat = s_ext[SUM_WIDTH];
    if (s2_take) begin
      primary_sum_next = p_sat ? SUM_MAX : p_ext[SUM_WIDTH-1:0];
      shadow_sum_next  = s_sat ? SUM_MAX : s_ext[SUM_WIDTH-1:0];
      sat_now          = s2_term_sat || p_sat || s_sat;
    end else begin
      primary_sum_next = primary_sum;
      shadow_sum_next  = shadow_sum;
      sat_now          = 1'b0;
    end
  end

  // A finished vector is handed to the queue with its status.
  assign push                 = advance && s2_valid && s2_last;
  assign push_sum             = primary_sum_next;
  assign push_flags.mismatch  = (primary_sum_next != shadow_sum_next);
  assign push_flags.saturated = saturate_seen || sat_now;
  assign push_flags.zero_norm = s2_zero;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      stride        <= cvn_pkg::STRIDE_RESET;
      skip_count    <= '0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      primary_sum   <= '0;
      shadow_sum    <= '0;
      saturate_seen <= 1'b0;
    end else begin
      if (cfg.valid) begin
        stride <= cfg.stride;
      end
      if (accept) begin
        if (elem.last) begin
          skip_count <= '0;
        end else if (take) begin
          skip_count <= stride - 1'b1;
        end else if (!stride_zero) begin
          skip_count <= skip_count - 1'b1;
        end
      end
      if (advance) begin
        s1_valid <= accept;
        s2_valid <= s1_valid;
        if (s2_valid) begin
          if (s2_last) begin
            primary_sum   <= '0;
            shadow_sum    <= '0;
            saturate_seen <= 1'b0;
          end else begin
            primary_sum   <= primary_sum_next;
            shadow_sum    <= shadow_sum_next;
            saturate_seen <= saturate_seen || sat_now;
          end
        end
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_last     <= elem.last;
      s1_take     <= take;
      s1_zero     <= stride_zero;
      sq_re       <= SQ_W'(mag_re) * SQ_W'(mag_re);
      sq_im       <= SQ_W'(mag_im) * SQ_W'(mag_im);
      s2_last     <= s1_last;
      s2_take     <= s1_take;
      s2_zero     <= s1_zero;
      s2_term_sat <= term_sat;
      s2_term     <= term_next;
    end
  end

endmodule

>>> sv/cvn_queue.sv
// ----------------------------------------------------------------------------
// cvn_queue
// Small first-in first-out queue of finished vector sums between the front
// and the back end.
// ----------------------------------------------------------------------------
module cvn_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cvn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> sv/cvn_back.sv
// ----------------------------------------------------------------------------
// cvn_back
// Takes one finished sum at a time, works out its integer square root one
// result bit per cycle and presents the norm in an output register.
// ----------------------------------------------------------------------------
module cvn_back #(
  parameter int SUM_WIDTH = cvn_pkg::SUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  logic [SUM_WIDTH-1:0] q_sum,
  input  cvn_pkg::cvn_flags_t  q_flags,
  output logic                 pop,
  cvn_out_if.source            result
);

  localparam int ROOT_W = (SUM_WIDTH + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W);
  localparam int RW_EXT = (ROOT_W > cvn_pkg::NORM_W) ? ROOT_W : cvn_pkg::NORM_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                  state;
  logic [CNT_W-1:0]            cnt;
  logic [RAD_W-1:0]            rad;
  logic [REM_W-1:0]            rem;
  logic [ROOT_W-1:0]           root;
  logic                        mismatch;
  logic                        saturated;
  logic [cvn_pkg::NORM_W-1:0]  norm;

  logic [REM_W-1:0]            rem_shift;
  logic [REM_W-1:0]            trial;
  logic                        fits;
  logic [RW_EXT-1:0]           root_ext;

  assign pop              = (state == ST_IDLE) && q_valid;
  assign result.valid     = (state == ST_DONE);
  assign result.norm      = norm;
  assign result.mismatch  = mismatch;
  assign result.saturated = saturated;

  // One restoring step: bring down two radicand bits, try 4*root + 1.
  always_comb begin
    rem_shift = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial     = {root, 2'b01};
    fits      = (rem_shift >= trial);
    root_ext  = RW_EXT'(root);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_flags.mismatch || q_flags.zero_norm) begin
              state <= ST_FIN;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (cnt == '0) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (result.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Root datapath and output register.
  always_ff @(posedge clk) begin
    if (pop) begin
      rad       <= RAD_W'(q_sum);
      rem       <= '0;
      root      <= '0;
      cnt       <= CNT_W'(ROOT_W - 1);
      mismatch  <= q_flags.mismatch;
      saturated <= q_flags.saturated;
    end else if (state == ST_RUN) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? (rem_shift - trial) : rem_shift;
      root <= {root[ROOT_W-2:0], fits};
      cnt  <= cnt - 1'b1;
    end
    if (state == ST_FIN) begin
      // Roots that do not fit the norm field stick at its maximum.
      if (root_ext > RW_EXT'(cvn_pkg::NORM_MAX)) begin
        norm <= cvn_pkg::NORM_MAX;
      end else begin
        norm <= root_ext[cvn_pkg::NORM_W-1:0];
      end
    end
  end

endmodule

>>> sv/complex_vector_norm_dual_check_unit.sv
// ----------------------------------------------------------------------------
// complex_vector_norm_dual_check_unit
// Euclidean norm of a streamed complex vector, accumulated in two redundant
// saturating sums that are compared when the vector ends.
//
//   Channel  Role   Carries
//   cfg      sink   stride register write
//   elem     sink   real_part, imag_part, last
//   result   source norm, mismatch, saturated (one per vector)
//
// The front takes one element per cycle while elem.ready is high and folds
// it into the sums through its squaring and term stages. The back end works
// out the root one bit per cycle and takes no new sum until its result is
// taken on result.ready. Up to QUEUE_DEPTH finished sums wait between the
// two; elem.ready falls only when a finished sum finds the queue full.
// Synchronous reset clears the sums, the queue and the sequencer; stride
// resets to one.
// ----------------------------------------------------------------------------
module complex_vector_norm_dual_check_unit #(
  parameter int SAMPLE_WIDTH = cvn_pkg::SAMPLE_WIDTH_DEF,
  parameter int SUM_WIDTH    = cvn_pkg::SUM_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = cvn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cvn_cfg_if.sink    cfg,
  cvn_in_if.sink     elem,
  cvn_out_if.source  result
);

  localparam int FLAGS_W = $bits(cvn_pkg::cvn_flags_t);
  localparam int ENTRY_W = SUM_WIDTH + FLAGS_W;

  logic                 push;
  logic [SUM_WIDTH-1:0] push_sum;
  cvn_pkg::cvn_flags_t  push_flags;
  logic                 q_full;
  logic                 q_valid;
  logic                 pop;
  logic [ENTRY_W-1:0]   q_data;
  logic [SUM_WIDTH-1:0] q_sum;
  cvn_pkg::cvn_flags_t  q_flags;

  // Accumulating front.
  cvn_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .elem       (elem),
    .q_full     (q_full),
    .push       (push),
    .push_sum   (push_sum),
    .push_flags (push_flags)
  );

  // Queue of finished sums.
  cvn_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_sum, push_flags}),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  assign q_sum   = q_data[ENTRY_W-1:FLAGS_W];
  assign q_flags = q_data[FLAGS_W-1:0];

  // Root back end.
  cvn_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_sum   (q_sum),
    .q_flags (q_flags),
    .pop     (pop),
    .result  (result)
  );

endmodule

>>> sv/cvn_checker.sv
// ----------------------------------------------------------------------------
// cvn_checker
// Port-level checks on the norm unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
module cvn_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [cvn_pkg::NORM_W-1:0] norm,
  input logic                       mismatch,
  input logic                       saturated
);

  // A waiting result stays offered until it is taken.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result request withdrawn before it was taken");

  // A waiting result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(norm) && $stable(mismatch) && $stable(saturated))
    else $error("result payload changed while stalled");

  // Disagreeing sums must never produce a norm.
  a_mismatch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && mismatch |-> norm == '0)
    else $error("non-zero norm reported with a mismatch");

  // Reset leaves no result on offer.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind complex_vector_norm_dual_check_unit cvn_checker u_cvn_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .norm      (result.norm),
  .mismatch  (result.mismatch),
  .saturated (result.saturated)
);
